@@ rtl/core/usan_pkg.sv @@
// ----------------------------------------------------------------------------
// usan_pkg
// Shared types and constants of the UTF-8 byte sanitizer.
// ----------------------------------------------------------------------------
package usan_pkg;

  localparam logic [7:0] ReplByte  = 8'h3F;
  localparam int unsigned MaxRun   = 4;
  localparam int unsigned HeldDepth = 3;

  typedef struct packed {
    logic [MaxRun-1:0][7:0] bytes;
    logic [2:0]             count;
    logic                   eot;
  } usan_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } usan_q_status_t;

endpackage

@@ rtl/core/usan_if.sv @@
// ----------------------------------------------------------------------------
// usan_if
// Valid/ready stream channels for the byte input and the byte output.
// ----------------------------------------------------------------------------
interface usan_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_text;

  modport source (output valid, output byte_in, output end_of_text, input ready);
  modport sink   (input valid, input byte_in, input end_of_text, output ready);
endinterface

interface usan_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       run_last;
  logic       text_last;

  modport source (output valid, output byte_out, output run_last, output text_last,
                  input ready);
  modport sink   (input valid, input byte_out, input run_last, input text_last,
                  output ready);
endinterface

@@ rtl/core/usan_front.sv @@
// ----------------------------------------------------------------------------
// usan_front
// Accepts bytes, tracks the open sequence and issues one request per byte
// that causes results.
// ----------------------------------------------------------------------------
module usan_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  usan_in_if.sink             in_i,
  input  usan_pkg::usan_q_status_t q_status_i,
  output logic                push_o,
  output usan_pkg::usan_req_t req_o
);

  logic [7:0] held_q [usan_pkg::HeldDepth];
  logic [1:0] cnt_q, cnt_d;
  logic [2:0] exp_q, exp_d;

  logic [7:0] b;
  logic       eot;
  logic       accept;
  logic       open;
  logic       is_cont;
  logic       is_lead;
  logic       fresh_emit;
  logic [7:0] fresh_byte;
  logic [2:0] fresh_len;
  logic       cont_in;
  logic       complete;
  logic       hold;
  logic [1:0] eff_cnt;
  logic       cur_emit;
  logic [7:0] cur_byte;
  logic       held_we;
  logic [1:0] held_idx;

  assign b      = in_i.byte_in;
  assign eot    = in_i.end_of_text;
  assign in_i.ready = !q_status_i.full;
  assign accept = in_i.valid && in_i.ready;

  always_comb begin
    open       = (exp_q != 3'd0);
    is_cont    = (b[7:6] == 2'b10);
    is_lead    = (b[7:6] == 2'b11);
    fresh_emit = !is_lead || eot;
    fresh_byte = b[7] ? usan_pkg::ReplByte : b;
    fresh_len  = (b[7:4] == 4'hF) ? 3'd4 : (b[7:5] == 3'b111) ? 3'd3 : 3'd2;
    cont_in    = open && is_cont;
    complete   = cont_in && (({1'b0, cnt_q} + 3'd1) >= exp_q);
    hold       = cont_in && !complete && !eot;
    eff_cnt    = (open && !hold) ? cnt_q : 2'd0;
    cur_emit   = complete || (cont_in && eot) || (!cont_in && fresh_emit);
    cur_byte   = complete ? b : (cont_in ? usan_pkg::ReplByte : fresh_byte);

    for (int i = 0; i < usan_pkg::MaxRun - 1; i++) begin
      if (2'(i) < eff_cnt) begin
        req_o.bytes[i] = complete ? held_q[i] : usan_pkg::ReplByte;
      end else begin
        req_o.bytes[i] = cur_byte;
      end
    end
    req_o.bytes[usan_pkg::MaxRun-1] = cur_byte;
    req_o.count = {1'b0, eff_cnt} + {2'b00, cur_emit};
    req_o.eot   = eot;
    push_o      = accept && (req_o.count != 3'd0);

    cnt_d    = cnt_q;
    exp_d    = exp_q;
    held_we  = 1'b0;
    held_idx = 2'd0;
    priority if (cont_in && (complete || eot)) begin
      cnt_d = 2'd0;
      exp_d = 3'd0;
    end else if (cont_in) begin
      cnt_d    = cnt_q + 2'd1;
      held_we  = (cnt_q != 2'd3);
      held_idx = cnt_q;
    end else if (is_lead && !eot) begin
      cnt_d    = 2'd1;
      exp_d    = fresh_len;
      held_we  = 1'b1;
      held_idx = 2'd0;
    end else begin
      cnt_d = 2'd0;
      exp_d = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      exp_q <= 3'd0;
    end else if (accept) begin
      cnt_q <= cnt_d;
      exp_q <= exp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && held_we) begin
      held_q[held_idx] <= b;
    end
  end

endmodule

@@ rtl/core/usan_queue.sv @@
// ----------------------------------------------------------------------------
// usan_queue
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module usan_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  usan_pkg::usan_req_t      req_i,
  input  logic                     pop_i,
  output usan_pkg::usan_q_status_t status_o,
  output usan_pkg::usan_req_t      head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  usan_pkg::usan_req_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == FullCnt);
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= req_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.full |-> !push_i) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.empty |-> !pop_i) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt) else $error("queue count overflow");

endmodule

@@ rtl/core/usan_back.sv @@
// ----------------------------------------------------------------------------
// usan_back
// Drains queued requests onto out_o, one byte per cycle while it is ready.
// ----------------------------------------------------------------------------
module usan_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  usan_pkg::usan_q_status_t q_status_i,
  input  usan_pkg::usan_req_t      head_i,
  output logic                     pop_o,
  usan_out_if.source               out_o
);

  logic [1:0] idx_q, idx_d;
  logic       last;
  logic       fire;

  always_comb begin
    last            = ({1'b0, idx_q} == (head_i.count - 3'd1));
    out_o.valid     = !q_status_i.empty;
    out_o.byte_out  = head_i.bytes[idx_q];
    out_o.run_last  = last;
    out_o.text_last = last && head_i.eot;
    fire            = out_o.valid && out_o.ready;
    pop_o           = fire && last;
    idx_d           = idx_q;
    if (fire) begin
      idx_d = last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

  a_head_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (head_i.count != 3'd0)) else $error("empty request queued");
  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ({1'b0, idx_q} < head_i.count)) else $error("index past run");
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status_i.empty |-> (idx_q == 2'd0)) else $error("index not cleared");

endmodule

@@ rtl/core/utf8_byte_sanitizer_top.sv @@
// ----------------------------------------------------------------------------
// utf8_byte_sanitizer_top
// UTF-8 stream cleanup: broken or stray sequence bytes become '?'.
// ----------------------------------------------------------------------------
//   channel  dir  fields                          handshake
//   in_i     in   byte_in[7:0], end_of_text       valid/ready
//   out_o    out  byte_out[7:0], run_last,        valid/ready
//                 text_last
//
// Sustains one byte per cycle in and out while the output is ready; an input
// byte is taken each cycle the request queue has room, and its results are
// queued and leave the queue head one byte per cycle while out_o is ready.
// A completed or broken sequence drains as a burst of up to four bytes.
// Reset clears the sequence tracker and the queue at once; no clearing pass.
// Output stalls back up through the queue (QueueDepth requests) to the input.
// ----------------------------------------------------------------------------
module utf8_byte_sanitizer_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  usan_in_if.sink    in_i,
  usan_out_if.source out_o
);

  usan_pkg::usan_q_status_t q_status;
  usan_pkg::usan_req_t      push_req;
  usan_pkg::usan_req_t      head_req;
  logic                     push;
  logic                     pop;

  usan_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .q_status_i (q_status),
    .push_o     (push),
    .req_o      (push_req)
  );

  usan_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .req_i    (push_req),
    .pop_i    (pop),
    .status_o (q_status),
    .head_o   (head_req)
  );

  usan_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .head_i     (head_req),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule
